### src/bfba_pkg.sv
package bfba_pkg;

  localparam int SLOT_W  = 6;
  localparam int AMT_W   = 16;
  localparam int COUNT_W = 7;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_REQ  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB,
    ST_DELIVER
  } state_t;

endpackage

### src/bfba_if.sv
interface bfba_in_if;
  import bfba_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] block_slot;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, command, block_slot, amount, input ready);
  modport sink   (input valid, command, block_slot, amount, output ready);
endinterface

interface bfba_out_if;
  import bfba_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [SLOT_W-1:0] chosen_block;
  logic [AMT_W-1:0]  space_left;

  modport source (output valid, granted, chosen_block, space_left, input ready);
  modport sink   (input valid, granted, chosen_block, space_left, output ready);
endinterface

### src/best_fit_block_allocator_top.sv
// Best-fit block allocator.
// Words arrive on in_ch (valid/ready). A load word (command 0) writes the
// free space of one block and clears its full mark; a request word
// (command 1) asks for amount units. Each input word yields exactly one
// result word on out_ch (valid/ready): granted, chosen_block, space_left.
// The user must see that block_count is written through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// The block works on one word at a time. A load writes the result register
// as it is accepted. A request streams the block table out of the single
// RAM read port, one entry per cycle; each registered read is compared with
// the best fit so far, and after the scan a write-back state stores the
// remainder and the result. The next word is accepted once the previous one
// is finished, even while its result still waits in the output register. If
// the receiver stalls, the finished result waits in an internal register and
// no further word is accepted until the output register frees up.
// Reset clears the controller, the output valid and block_count. The table
// is not cleared and has no clearing pass: every block must be loaded before
// a request reads it, and the block itself does not enforce this.
module best_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfba_pkg::COUNT_W-1:0]  cfg_wdata,
  bfba_in_if.sink                       in_ch,
  bfba_out_if.source                    out_ch
);
  import bfba_pkg::*;

  // Index width, counter width (holds NUM_BLOCKS itself) and compare widths.
  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CW    = $clog2(NUM_BLOCKS + 1);
  localparam int BW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int SW    = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int EXT_W = IDX_W + SLOT_W;
  localparam int RAM_W = AMT_W + 1;

  state_t state, state_next;

  logic [COUNT_W-1:0] block_count;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      limit;
  logic [BW-1:0]      bc_ext;
  logic [AMT_W-1:0]   req_amt;

  // Compare stage of the scan.
  logic               pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [AMT_W-1:0]   best_rem;

  // Finished result waiting for the output register.
  logic               res_granted;
  logic [SLOT_W-1:0]  res_block;
  logic [AMT_W-1:0]   res_space;

  // Output register.
  logic               out_valid;
  logic               out_granted;
  logic [SLOT_W-1:0]  out_block;
  logic [AMT_W-1:0]   out_space;

  // RAM ports: {full mark, free space}.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;

  logic               accept;
  logic               issue;
  logic               out_free;
  logic [SW-1:0]      slot_ext;
  logic               slot_ok;
  logic [EXT_W-1:0]   best_ext;
  logic               entry_full;
  logic [AMT_W-1:0]   entry_space;
  logic               fits;
  logic [AMT_W-1:0]   rem;

  assign bc_ext   = BW'(block_count);
  assign limit    = (bc_ext > BW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : bc_ext[CW-1:0];
  assign accept   = in_ch.valid && in_ch.ready;
  assign issue    = (state == ST_SCAN) && (cnt < limit);
  assign out_free = !out_valid || out_ch.ready;
  assign slot_ext = SW'(in_ch.block_slot);
  assign slot_ok  = slot_ext < SW'(NUM_BLOCKS);
  assign best_ext = EXT_W'(best_idx);

  assign entry_full  = ram_rdata[RAM_W-1];
  assign entry_space = ram_rdata[AMT_W-1:0];
  assign fits        = !entry_full && (entry_space >= req_amt);
  assign rem         = entry_space - req_amt;

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.granted      = out_granted;
  assign out_ch.chosen_block = out_block;
  assign out_ch.space_left   = out_space;

  bfba_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the single RAM write port. A load writes in the cycle it
  // is accepted; a granted request writes back its remainder after the scan.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_ch.command) == CMD_REQ) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DELIVER;
            if (slot_ok) begin
              ram_we    = 1'b1;
              ram_waddr = slot_ext[IDX_W-1:0];
              ram_wdata = {1'b0, in_ch.amount};
            end
          end
        end
      end
      ST_SCAN: begin
        if (!issue && !pend) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        state_next = ST_DELIVER;
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = best_idx;
          ram_wdata = {(best_rem == '0), best_rem};
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      found       <= 1'b0;
      cnt         <= '0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end

      // While scanning, one read is issued per cycle; its registered data is compared in the next cycle.
      pend   <= issue;
      rd_idx <= cnt[IDX_W-1:0];
      if (issue) begin
        cnt <= cnt + 1'b1;
      end

      if (pend && fits && (!found || rem < best_rem)) begin
        found    <= 1'b1;
        best_idx <= rd_idx;
        best_rem <= rem;
      end

      if (state == ST_IDLE && accept) begin
        req_amt <= in_ch.amount;
        cnt     <= '0;
        found   <= 1'b0;
        if (cmd_t'(in_ch.command) == CMD_LOAD) begin
          res_granted <= 1'b0;
          res_block   <= in_ch.block_slot;
          res_space   <= slot_ok ? in_ch.amount : '0;
        end
      end

      if (state == ST_WB) begin
        res_granted <= found;
        res_block   <= found ? best_ext[SLOT_W-1:0] : '0;
        res_space   <= found ? best_rem : '0;
      end

      if (state == ST_DELIVER && out_free) begin
        out_valid   <= 1'b1;
        out_granted <= res_granted;
        out_block   <= res_block;
        out_space   <= res_space;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/bfba_ram.sv
module bfba_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
